// File: hdl/permutation_combination_count_top_defines.svh
// ----------------------------------------------------------------------------
// Permutation and combination counter: assertion macros
// Shared property forms for the checker. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_COMBINATION_COUNT_TOP_DEFINES_SVH
`define PERMUTATION_COMBINATION_COUNT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Control word, condition codes and step addresses of the counter's
// microprogram, shared by the control store, sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  // Microprogram address.
  typedef logic [2:0] upc_t;

  // Step addresses of the program.
  localparam upc_t STEP_IDLE  = 3'd0;
  localparam upc_t STEP_CHECK = 3'd1;
  localparam upc_t STEP_MUL   = 3'd2;
  localparam upc_t STEP_DIV   = 3'd3;
  localparam upc_t STEP_FIN   = 3'd4;
  localparam upc_t STEP_EMIT  = 3'd5;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL,
    DP_DIV,
    DP_FIN,
    DP_EMIT
  } dp_op_t;

  // Branch conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_DONE,
    COND_PERM,
    COND_MORE,
    COND_OUT_FREE
  } cond_t;

  // Operation codes of the op field.
  localparam logic OP_COMB = 1'b0;
  localparam logic OP_PERM = 1'b1;

  // One control word: operation, condition, taken and fall targets.
  typedef struct packed {
    dp_op_t dp_op;
    cond_t  cond;
    upc_t   jt;
    upc_t   jf;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic done;
    logic perm;
    logic more;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/pcc_ucode_rom.sv
// ----------------------------------------------------------------------------
// pcc_ucode_rom
// Read-only control store holding the counter's microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_ucode_rom
  import pcc_pkg::*;
(
  input  upc_t   addr,
  output uword_t word
);

  // Program: accept, test loop end, multiply, divide bytewise, fix, emit.
  always_comb begin
    unique case (addr)
      STEP_IDLE:  word = '{DP_LOAD, COND_IN_VALID, STEP_CHECK, STEP_IDLE};
      STEP_CHECK: word = '{DP_NOP,  COND_DONE,     STEP_EMIT,  STEP_MUL};
      STEP_MUL:   word = '{DP_MUL,  COND_PERM,     STEP_CHECK, STEP_DIV};
      STEP_DIV:   word = '{DP_DIV,  COND_MORE,     STEP_DIV,   STEP_FIN};
      STEP_FIN:   word = '{DP_FIN,  COND_ALWAYS,   STEP_CHECK, STEP_CHECK};
      STEP_EMIT:  word = '{DP_EMIT, COND_OUT_FREE, STEP_IDLE,  STEP_EMIT};
      default:    word = '{DP_NOP,  COND_ALWAYS,   STEP_IDLE,  STEP_IDLE};
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/pcc_sequencer.sv
// ----------------------------------------------------------------------------
// pcc_sequencer
// Step counter with two-way conditional branch over the control store.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_sequencer
  import pcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output uword_t  uword
);

  upc_t upc;
  upc_t upc_next;
  logic taken;

  pcc_ucode_rom u_rom (
    .addr (upc),
    .word (uword)
  );

  // Evaluate the branch condition of the current word.
  always_comb begin
    unique case (uword.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_IN_VALID: taken = status.in_valid;
      COND_DONE:     taken = status.done;
      COND_PERM:     taken = status.perm;
      COND_MORE:     taken = status.more;
      COND_OUT_FREE: taken = status.out_free;
      default:       taken = 1'b1;
    endcase
  end

  assign upc_next = taken ? uword.jt : uword.jf;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath
// Accumulator, one narrow multiplier, a byte-per-cycle exact divider and
// the output register, all driven by the control word.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_datapath
  import pcc_pkg::*;
#(
  parameter int N_MAX        = 255,
  parameter int RESULT_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  uword_t      uword,
  output status_t     status,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  n,
  input  logic [7:0]  r,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] count,
  output logic        overflow,
  output logic        invalid
);

  localparam int PROD_W = RESULT_WIDTH + 8;
  localparam int NBYTES = (PROD_W + 7) / 8;
  localparam int DIV_W  = NBYTES * 8;
  localparam int BCNT_W = $clog2(NBYTES);

  // Divides {rem, byte} by d; rem < d keeps the quotient within 8 bits.
  function automatic logic [15:0] div_byte(input logic [7:0] rem_in,
                                           input logic [7:0] byte_in,
                                           input logic [7:0] d);
    logic [8:0] part;
    logic [7:0] q;
    part = {1'b0, rem_in};
    q    = '0;
    for (int i = 7; i >= 0; i--) begin
      part = {part[7:0], byte_in[i]};
      if (part >= {1'b0, d}) begin
        part = part - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return {q, part[7:0]};
  endfunction

  logic                    op_q;
  logic [7:0]              n_q;
  logic [7:0]              lim;
  logic [8:0]              k;
  logic [RESULT_WIDTH-1:0] acc;
  logic [DIV_W-1:0]        quo;
  logic [7:0]              rem;
  logic [BCNT_W-1:0]       bcnt;
  logic                    ovf;
  logic                    inv;

  logic [7:0]              m;
  logic [PROD_W-1:0]       prod;
  logic [7:0]              n_minus_r;
  logic [15:0]             div_out;
  logic                    out_free;

  // Current factor n - k + 1, and its product with the accumulator.
  assign m         = n_q - k[7:0] + 8'd1;
  assign prod      = PROD_W'(acc) * PROD_W'(m);
  assign n_minus_r = n - r;
  assign div_out   = div_byte(rem, quo[DIV_W-1 -: 8], k[7:0]);
  assign out_free  = !out_valid || !out_stall;

  // Status to the sequencer.
  assign status.in_valid = in_valid;
  assign status.done     = inv || ovf || (k > {1'b0, lim});
  assign status.perm     = (op_q == OP_PERM);
  assign status.more     = (bcnt != BCNT_W'(NBYTES - 1));
  assign status.out_free = out_free;

  assign in_stall = (uword.dp_op != DP_LOAD);

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (uword.dp_op)
      DP_LOAD: begin
        op_q <= op;
        n_q  <= n;
        inv  <= (r > n) || ({8'd0, n} > 16'(N_MAX));
        lim  <= (op == OP_PERM || r <= n_minus_r) ? r : n_minus_r;
        k    <= 9'd1;
        acc  <= RESULT_WIDTH'(1);
        ovf  <= 1'b0;
      end
      DP_MUL: begin
        if (op_q == OP_PERM) begin
          // Falling product: saturate once it leaves the result width.
          if (prod[PROD_W-1:RESULT_WIDTH] != '0) begin
            ovf <= 1'b1;
            acc <= '1;
          end else begin
            acc <= prod[RESULT_WIDTH-1:0];
          end
          k <= k + 9'd1;
        end else begin
          quo  <= DIV_W'(prod);
          rem  <= '0;
          bcnt <= '0;
        end
      end
      DP_DIV: begin
        // One quotient byte per cycle, most significant first.
        quo  <= {quo[DIV_W-9:0], div_out[15:8]};
        rem  <= div_out[7:0];
        bcnt <= bcnt + BCNT_W'(1);
      end
      DP_FIN: begin
        // The quotient is C(n,k); past the result width it saturates.
        if (quo[DIV_W-1:RESULT_WIDTH] != '0) begin
          ovf <= 1'b1;
          acc <= '1;
        end else begin
          acc <= quo[RESULT_WIDTH-1:0];
        end
        k <= k + 9'd1;
      end
      default: begin
      end
    endcase
  end

  // Output register; a result waits here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uword.dp_op == DP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uword.dp_op == DP_EMIT && out_free) begin
      count    <= inv ? 64'd0 : 64'(acc);
      overflow <= ovf && !inv;
      invalid  <= inv;
    end
  end

endmodule

`default_nettype wire

// File: hdl/permutation_combination_count_top.sv
// ----------------------------------------------------------------------------
// permutation_combination_count_top: nPr and nCr counter, one request at a time.
// nPr: one multiply step per factor of the falling product.
// nCr: min(r, n - r) factors, each a multiply, a bytewise divide and a fix step,
// NBYTES = ceil((RESULT_WIDTH+8)/8) quotient bytes per divide, MSB first.
// Synchronous reset returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_combination_count_top
  import pcc_pkg::*;
#(
  parameter int N_MAX        = 255,
  parameter int RESULT_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  n,
  input  logic [7:0]  r,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] count,
  output logic        overflow,
  output logic        invalid
);

  uword_t  uword;
  status_t status;

  // Microprogram sequencer.
  pcc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  // Arithmetic and output register.
  pcc_datapath #(
    .N_MAX        (N_MAX),
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .uword     (uword),
    .status    (status),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .n         (n),
    .r         (r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count     (count),
    .overflow  (overflow),
    .invalid   (invalid)
  );

endmodule

`default_nettype wire

// File: hdl/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "permutation_combination_count_top_defines.svh"

module pcc_checker #(
  parameter int RESULT_WIDTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] count,
  input logic        overflow,
  input logic        invalid
);

  localparam logic [63:0] SAT = 64'((65'd1 << RESULT_WIDTH) - 65'd1);

  // A rejected request carries a zero count and no overflow.
  `PCC_ASSERT_SAME(a_invalid_zero, out_valid && invalid, count == 64'd0 && !overflow, "invalid result not zero")

  // An overflowing result is saturated to the result width.
  `PCC_ASSERT_SAME(a_ovf_saturate, out_valid && overflow, count == SAT, "overflow result not saturated")

  // A valid request always counts at least one arrangement.
  `PCC_ASSERT_SAME(a_count_nonzero, out_valid && !invalid, count != 64'd0, "valid request gave zero")

  // Once a request is taken, the next one waits until this one is done.
  `PCC_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second request taken at once")

  // A stalled result holds.
  `PCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(count), "stalled result changed")

endmodule

bind permutation_combination_count_top pcc_checker #(
  .RESULT_WIDTH (RESULT_WIDTH)
) u_checker (.*);

`default_nettype wire

// File: tb/tb_permutation_combination_count_top.sv
// ----------------------------------------------------------------------------
// tb_permutation_combination_count_top: self-checking bench for the counter
// Drives nPr and nCr requests with random idle gaps on both sides, predicts
// each count, overflow and invalid flag, and checks results in order.
// ----------------------------------------------------------------------------
module tb_permutation_combination_count_top
  import pcc_pkg::*;
();

  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          TAIL_CYCLES    = 2000;
  localparam int          SET_LIMIT      = 255;
  localparam logic [63:0] COUNT_SAT      = '1;
  localparam int          PRINT_LIMIT    = 40;

  // One predicted result, kept with the request that caused it.
  typedef struct {
    logic [63:0] count;
    logic        overflow;
    logic        invalid;
    logic        op;
    logic [7:0]  n;
    logic [7:0]  r;
  } count_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [7:0]  n;
  logic [7:0]  r;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] count;
  logic        overflow;
  logic        invalid;

  count_result_t pending_counts[$];
  int            mismatch_total;
  bit            sender_steady;
  bit            receiver_steady;

  permutation_combination_count_top u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .n        (n),
    .r        (r),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .count    (count),
    .overflow (overflow),
    .invalid  (invalid)
  );

  // Free-running clock, period 8.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Greatest common divisor by repeated remainder.
  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 64'd0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Multiplies two counts; reports whether the product still fits in 64 bits.
  function automatic bit fits_product(input logic [63:0] a, input logic [63:0] b,
                                      output logic [63:0] p);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    p = wide[63:0];
    return (wide[127:64] == 64'd0);
  endfunction

  // Predicts the count and flags for one request.
  function automatic count_result_t predict_count(input logic o, input logic [7:0] nv,
                                                  input logic [7:0] rv);
    count_result_t res;
    logic [63:0]   acc;
    logic [63:0]   g;
    logic [63:0]   kr;
    logic [63:0]   mr;
    int            pick;
    res.op       = o;
    res.n        = nv;
    res.r        = rv;
    res.count    = 64'd0;
    res.overflow = 1'b0;
    res.invalid  = 1'b0;
    if (rv > nv || int'(nv) > SET_LIMIT) begin
      res.invalid = 1'b1;
      return res;
    end
    acc = 64'd1;
    if (o == OP_PERM) begin
      // Falling product, stopping at the first factor that overflows.
      for (int i = 0; i < int'(rv); i++) begin
        if (!fits_product(acc, 64'(nv) - 64'(i), acc)) begin
          res.overflow = 1'b1;
          acc = COUNT_SAT;
          break;
        end
      end
    end else begin
      // Binomial built one factor at a time, using the smaller of r and n - r.
      pick = (int'(rv) > int'(nv) - int'(rv)) ? int'(nv) - int'(rv) : int'(rv);
      for (int k = 1; k <= pick; k++) begin
        g  = gcd64(acc, 64'(k));
        kr = 64'(k) / g;
        mr = (64'(nv) - 64'(k) + 64'd1) / kr;
        if (!fits_product(acc / g, mr, acc)) begin
          res.overflow = 1'b1;
          acc = COUNT_SAT;
          break;
        end
      end
    end
    res.count = acc;
    return res;
  endfunction

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic report_mismatch(input string msg);
    if (mismatch_total < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_total++;
  endtask

  // Sends one request; called and returns at a falling edge.
  task automatic send_request(input logic o, input logic [7:0] nv, input logic [7:0] rv);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op       <= o;
    n        <= nv;
    r        <= rv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_counts.push_back(predict_count(o, nv, rv));
    @(negedge clk);
  endtask

  // Holds the sender until every predicted result has been checked.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
  endtask

  // Extremes of n and r, empty choices and rejected operands.
  task automatic test_edge_operands();
    send_request(OP_COMB, 8'd0,   8'd0);
    send_request(OP_PERM, 8'd0,   8'd0);
    send_request(OP_COMB, 8'd0,   8'd1);
    send_request(OP_PERM, 8'd0,   8'd255);
    send_request(OP_COMB, 8'd254, 8'd255);
    send_request(OP_COMB, 8'd255, 8'd0);
    send_request(OP_PERM, 8'd255, 8'd0);
    send_request(OP_COMB, 8'd255, 8'd255);
    send_request(OP_COMB, 8'd255, 8'd1);
    send_request(OP_PERM, 8'd255, 8'd1);
    send_request(OP_COMB, 8'd255, 8'd254);
    send_request(OP_PERM, 8'd1,   8'd1);
    send_request(OP_COMB, 8'd128, 8'd127);
  endtask

  // Counts just below and just above the 64-bit limit, for both operations.
  task automatic test_overflow_limits();
    send_request(OP_PERM, 8'd20,  8'd20);
    send_request(OP_PERM, 8'd21,  8'd21);
    send_request(OP_PERM, 8'd255, 8'd8);
    send_request(OP_PERM, 8'd255, 8'd9);
    send_request(OP_PERM, 8'd255, 8'd255);
    send_request(OP_COMB, 8'd67,  8'd33);
    send_request(OP_COMB, 8'd67,  8'd34);
    send_request(OP_COMB, 8'd68,  8'd34);
    send_request(OP_COMB, 8'd170, 8'd85);
    send_request(OP_COMB, 8'd255, 8'd127);
  endtask

  // Draws one random request, weighted toward short, well-formed requests.
  task automatic send_random_request();
    int   kind;
    int   nv;
    int   rv;
    logic o;
    kind = $urandom_range(0, 99);
    o    = 1'($urandom_range(0, 1));
    if (kind < 55) begin
      nv = $urandom_range(0, 40);
      rv = $urandom_range(0, nv);
    end else if (kind < 70) begin
      nv = $urandom_range(0, 255);
      rv = $urandom_range(0, nv);
    end else if (kind < 85) begin
      // Around the overflow boundary.
      if (o == OP_PERM) begin
        nv = $urandom_range(8, 255);
        rv = $urandom_range(0, 25);
      end else begin
        nv = $urandom_range(55, 80);
        rv = $urandom_range(20, nv - 20);
      end
    end else if (kind < 95) begin
      nv = $urandom_range(0, 254);
      rv = $urandom_range(nv + 1, 255);
    end else begin
      nv = $urandom_range(0, 255);
      rv = $urandom_range(0, 255);
    end
    send_request(o, 8'(nv), 8'(rv));
  endtask

  // Random requests in blocks, some blocks without any idling.
  task automatic test_random_requests();
    for (int blk = 0; blk < 10; blk++) begin
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100; i++) begin
        send_random_request();
      end
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  // The sender stops until the counter has delivered everything, then resumes.
  task automatic test_drain_pause();
    repeat (5) send_random_request();
    wait_for_drain();
    @(negedge clk);
    repeat (5) send_random_request();
  endtask

  // Receiver: stalls a random number of cycles before taking each result.
  initial begin : result_receiver
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = receiver_steady ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    count_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0h ovf=%0b inv=%0b",
                                  count, overflow, invalid));
      end else begin
        want = pending_counts.pop_front();
        if (count !== want.count) begin
          report_mismatch($sformatf("op=%0b n=%0d r=%0d count %0h, want %0h",
                                    want.op, want.n, want.r, count, want.count));
        end
        if (overflow !== want.overflow) begin
          report_mismatch($sformatf("op=%0b n=%0d r=%0d overflow %0b, want %0b",
                                    want.op, want.n, want.r, overflow, want.overflow));
        end
        if (invalid !== want.invalid) begin
          report_mismatch($sformatf("op=%0b n=%0d r=%0d invalid %0b, want %0b",
                                    want.op, want.n, want.r, invalid, want.invalid));
        end
      end
    end
  end

  // Watchdog: ends the run if no request or result moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_permutation_combination_count_top: FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    op              = OP_COMB;
    n               = 8'd0;
    r               = 8'd0;
    mismatch_total  = 0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_edge_operands();
    test_overflow_limits();
    test_drain_pause();
    test_random_requests();

    // Let the counter finish, then give it time to show any stray result.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_counts.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_counts.size()));
    end
    if (mismatch_total == 0) begin
      $display("tb_permutation_combination_count_top: PASS");
    end else begin
      $display("tb_permutation_combination_count_top: FAIL");
    end
    $finish;
  end

endmodule
